// ----- design/pwft_pkg.sv -----
// Package: shared constants, codes and types of the pulse width frame transmitter.
`timescale 1ns / 1ps

package pwft_pkg;

    localparam int MSG_BYTES     = 128;
    localparam int MSG_ADDR_W    = $clog2(MSG_BYTES);
    localparam int WORD_BITS     = 10;
    localparam int STOP_BITS     = 3;
    localparam int PREAMBLE_BITS = 7;
    localparam int BIT_CNT_W     = 4;
    localparam int TICK_W        = 8;
    localparam int WORD_CNT_W    = 9;
    localparam int CFG_IDX_W     = 3;

    localparam logic [BIT_CNT_W-1:0] STOP_LIMIT  = BIT_CNT_W'(STOP_BITS);
    localparam logic [BIT_CNT_W-1:0] PRE_LIMIT   = BIT_CNT_W'(PREAMBLE_BITS);
    localparam logic [BIT_CNT_W-1:0] WORD_LIMIT  = BIT_CNT_W'(WORD_BITS + STOP_BITS);

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_START = 2'd1,
        MODE_TICK  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        PH_STOP = 2'd0,
        PH_PRE  = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIT_TICKS   = 3'd0,
        CFG_SHORT_HIGH  = 3'd1,
        CFG_LONG_HIGH   = 3'd2,
        CFG_PRE_TICKS   = 3'd3,
        CFG_STOP_HIGH   = 3'd4
    } cfg_idx_t;

    // Write request into the message store
    typedef struct packed {
        logic                  en;
        logic [MSG_ADDR_W-1:0] addr;
        logic [7:0]            data;
    } store_wr_t;

endpackage

// ----- design/pulse_width_frame_transmitter.sv -----
// Top level: request pipeline, frame sequencer, config registers and result register.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid in_ready mode byte_index byte_value    | to block
//          | word_total                                      |
//  out     | out_valid out_ready tx_level frame_done busy_res| from block
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data          | to block
//
// One request per cycle sustained while the result is taken; a request passes
// the input register, then the sequencer logic into the result register.
// Reset clears all control state and loads the register defaults; the
// message store is not cleared. A stalled result holds the result register
// and the input register; while the result waits, the input accepts a new
// request only as long as the input register is empty.
`timescale 1ns / 1ps

module pulse_width_frame_transmitter
    import pwft_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            mode,
    input  logic [6:0]            byte_index,
    input  logic [7:0]            byte_value,
    input  logic [8:0]            word_total,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  tx_level,
    output logic                  frame_done,
    output logic                  busy_res,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]            cfg_data
);

    // Input register
    logic                  s1_valid_reg;
    logic [1:0]            s1_mode_reg;
    logic [6:0]            s1_index_reg;
    logic [7:0]            s1_value_reg;
    logic [8:0]            s1_total_reg;

    // Result register
    logic                  out_valid_reg;
    logic                  tx_level_reg;
    logic                  frame_done_reg;
    logic                  busy_res_reg;

    // Config registers
    logic [TICK_W-1:0]     bit_ticks_reg;
    logic [TICK_W-1:0]     short_high_reg;
    logic [TICK_W-1:0]     long_high_reg;
    logic [TICK_W-1:0]     pre_ticks_reg;
    logic [TICK_W-1:0]     stop_high_reg;

    // Sequencer state
    phase_t                phase_reg, phase_next;
    logic [TICK_W-1:0]     tick_cnt_reg, tick_cnt_next;
    logic [BIT_CNT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic [WORD_CNT_W-1:0] word_cnt_reg, word_cnt_next;
    logic [WORD_CNT_W-1:0] frame_words_reg, frame_words_next;
    logic                  sending_reg, sending_next;

    logic                  advance;
    logic                  do_step;
    logic                  do_tick;
    logic                  lvl;
    logic                  done;
    logic [TICK_W-1:0]     tick_limit;
    logic [BIT_CNT_W-1:0]  bit_limit;
    logic                  tick_wrap;
    logic                  bit_wrap;
    logic                  word_wrap;
    logic [BIT_CNT_W-1:0]  data_idx;
    logic [WORD_BITS-1:0]  send_word;
    store_wr_t             store_wr;

    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || advance;
    assign do_step   = s1_valid_reg && advance;
    assign do_tick   = do_step && (s1_mode_reg == MODE_TICK) && sending_reg;
    assign cfg_ready = 1'b1;

    assign out_valid  = out_valid_reg;
    assign tx_level   = tx_level_reg;
    assign frame_done = frame_done_reg;
    assign busy_res   = busy_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_mode_reg  <= mode;
            s1_index_reg <= byte_index;
            s1_value_reg <= byte_value;
            s1_total_reg <= word_total;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_ticks_reg  <= 8'd8;
            short_high_reg <= 8'd2;
            long_high_reg  <= 8'd4;
            pre_ticks_reg  <= 8'd4;
            stop_high_reg  <= 8'd2;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_BIT_TICKS:  bit_ticks_reg  <= cfg_data;
                CFG_SHORT_HIGH: short_high_reg <= cfg_data;
                CFG_LONG_HIGH:  long_high_reg  <= cfg_data;
                CFG_PRE_TICKS:  pre_ticks_reg  <= cfg_data;
                CFG_STOP_HIGH:  stop_high_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Store writes only while idle; the read follows the current word position
    always_comb
    begin
        store_wr.en   = do_step && (s1_mode_reg == MODE_LOAD) && !sending_reg;
        store_wr.addr = s1_index_reg[MSG_ADDR_W-1:0];
        store_wr.data = s1_value_reg;
    end

    pwft_msg_store u_store (
        .clk       (clk),
        .wr        (store_wr),
        .rd_addr   (word_cnt_reg[MSG_ADDR_W:1]),
        .word_odd  (word_cnt_reg[0]),
        .send_word (send_word)
    );

    // Period, bit-count and word-count wrap detection
    always_comb
    begin
        tick_limit = (phase_reg == PH_PRE) ? pre_ticks_reg : bit_ticks_reg;
        unique case (phase_reg)
            PH_STOP: bit_limit = STOP_LIMIT;
            PH_PRE:  bit_limit = PRE_LIMIT;
            default: bit_limit = WORD_LIMIT;
        endcase
        tick_wrap = ({1'b0, tick_cnt_reg} + 9'd1) >= {1'b0, tick_limit};
        bit_wrap  = ({1'b0, bit_cnt_reg} + 5'd1) >= {1'b0, bit_limit};
        word_wrap = ({1'b0, word_cnt_reg} + 10'd1) >= {1'b0, frame_words_reg};
    end

    // Next state
    always_comb
    begin
        phase_next       = phase_reg;
        tick_cnt_next    = tick_cnt_reg;
        bit_cnt_next     = bit_cnt_reg;
        word_cnt_next    = word_cnt_reg;
        frame_words_next = frame_words_reg;
        sending_next     = sending_reg;
        done             = 1'b0;

        if (do_step && (s1_mode_reg == MODE_START) && !sending_reg)
        begin
            sending_next     = 1'b1;
            frame_words_next = s1_total_reg;
            phase_next       = PH_STOP;
            tick_cnt_next    = '0;
            bit_cnt_next     = '0;
            word_cnt_next    = '0;
        end
        else if (do_tick)
        begin
            tick_cnt_next = tick_wrap ? '0 : tick_cnt_reg + 8'd1;
            if (tick_wrap)
            begin
                bit_cnt_next = bit_wrap ? '0 : bit_cnt_reg + 4'd1;
                if (bit_wrap)
                begin
                    unique case (phase_reg)
                        PH_STOP: phase_next = PH_PRE;
                        PH_PRE:  phase_next = PH_DATA;
                        default:
                        begin
                            if (word_wrap)
                            begin
                                // Frame complete: drop back to idle
                                done          = 1'b1;
                                sending_next  = 1'b0;
                                word_cnt_next = '0;
                                phase_next    = PH_STOP;
                            end
                            else
                            begin
                                word_cnt_next = word_cnt_reg + 9'd1;
                            end
                        end
                    endcase
                end
            end
        end
    end

    // Line level for this tick
    always_comb
    begin
        data_idx = bit_cnt_reg - STOP_LIMIT;
        lvl      = 1'b0;
        if (do_tick)
        begin
            unique case (phase_reg)
                PH_STOP: lvl = (tick_cnt_reg < stop_high_reg) && (bit_cnt_reg == '0);
                PH_PRE:  lvl = tick_cnt_reg < short_high_reg;
                default:
                begin
                    if (bit_cnt_reg < STOP_LIMIT)
                    begin
                        lvl = (bit_cnt_reg == '0) && (tick_cnt_reg < short_high_reg);
                    end
                    else
                    begin
                        lvl = (tick_cnt_reg < short_high_reg) ||
                              ((tick_cnt_reg < long_high_reg) && !send_word[data_idx]);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_STOP;
            tick_cnt_reg    <= '0;
            bit_cnt_reg     <= '0;
            word_cnt_reg    <= '0;
            frame_words_reg <= '0;
            sending_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            tick_cnt_reg    <= tick_cnt_next;
            bit_cnt_reg     <= bit_cnt_next;
            word_cnt_reg    <= word_cnt_next;
            frame_words_reg <= frame_words_next;
            sending_reg     <= sending_next;
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_step)
        begin
            tx_level_reg   <= lvl;
            frame_done_reg <= done;
            busy_res_reg   <= sending_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && frame_done_reg |-> !busy_res_reg)
        else $error("frame end reported while still busy");

    a_idle_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        !sending_reg |-> (tick_cnt_reg == '0) && (bit_cnt_reg == '0) &&
                         (word_cnt_reg == '0) && (phase_reg == PH_STOP))
        else $error("counters not cleared while idle");

    a_bit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PRE) || (bit_cnt_reg < WORD_LIMIT))
        else $error("bit counter out of range");

    a_store_idle: assert property (@(posedge clk) disable iff (!rst_n)
        store_wr.en |-> !sending_reg && !sending_next)
        else $error("store written during a frame");
`endif

endmodule

// ----- design/pwft_msg_store.sv -----
// Message store: byte memory with registered read and word assembly with parity.
`timescale 1ns / 1ps

module pwft_msg_store
    import pwft_pkg::*;
(
    input  logic                  clk,
    input  store_wr_t             wr,
    input  logic [MSG_ADDR_W-1:0] rd_addr,
    input  logic                  word_odd,
    output logic [WORD_BITS-1:0]  send_word
);

    logic [7:0] store_mem [MSG_BYTES];
    logic [7:0] rd_data_reg;
    logic       par_odd;
    logic [1:0] par_bits;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            store_mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    // Odd word positions carry the complemented parity code
    always_comb
    begin
        par_odd = ^rd_data_reg;
        if (word_odd)
        begin
            par_bits = par_odd ? 2'd1 : 2'd3;
        end
        else
        begin
            par_bits = par_odd ? 2'd2 : 2'd0;
        end
        send_word = {par_bits, rd_data_reg};
    end

endmodule

// ----- sim/tb.sv -----
// Testbench for the pulse width frame transmitter: every request's result checked against a predictor.
`timescale 1ns / 1ps

module tb;
    import pwft_pkg::*;

    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 6;
    localparam int RANDOM_ITEMS = 450;

    typedef struct packed {
        logic level;
        logic done;
        logic busy;
    } line_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] mode = MODE_TICK;
    logic [6:0] byte_index = '0;
    logic [7:0] byte_value = '0;
    logic [8:0] word_total = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic tx_level;
    logic frame_done;
    logic busy_res;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    // predicted block state
    logic [7:0] msg_copy [MSG_BYTES];
    logic [TICK_W-1:0] tick_cnt = '0;
    logic [BIT_CNT_W-1:0] bit_cnt = '0;
    logic [WORD_CNT_W-1:0] word_cnt = '0;
    phase_t phase = PH_STOP;
    logic [WORD_BITS-1:0] tx_word = '0;
    logic busy = 1'b0;
    logic [WORD_CNT_W-1:0] frame_len = '0;
    logic [7:0] per_bit = 8'd8;
    logic [7:0] hi_short = 8'd2;
    logic [7:0] hi_long = 8'd4;
    logic [7:0] per_pre = 8'd4;
    logic [7:0] hi_stop = 8'd2;

    line_result_t level_q [$];
    line_result_t want;
    int errors = 0;
    int items_sent = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    bit calm = 1'b0;

    pulse_width_frame_transmitter dut (.*);

    always #5 clk = ~clk;

    function automatic bit next_count(inout int ct, input int limit);
        ct++;
        if (ct >= limit)
        begin
            ct = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [WORD_BITS-1:0] word_for(int pos);
        logic [7:0] b;
        logic [1:0] par;
        b = msg_copy[(pos >> 1) % MSG_BYTES];
        if (pos % 2 == 1)
            par = (^b) ? 2'd1 : 2'd3;
        else
            par = (^b) ? 2'd2 : 2'd0;
        return {par, b};
    endfunction

    function automatic line_result_t predict_tick();
        line_result_t r;
        int t;
        int bc;
        int wc;
        r = '0;
        t = tick_cnt;
        bc = bit_cnt;
        wc = word_cnt;
        case (phase)
            PH_STOP:
            begin
                r.level = (t < hi_stop) && (bc == 0);
                if (next_count(t, per_bit) && next_count(bc, STOP_BITS))
                    phase = PH_PRE;
            end
            PH_PRE:
            begin
                r.level = (t < hi_short);
                if (next_count(t, per_pre) && next_count(bc, PREAMBLE_BITS))
                begin
                    phase = PH_DATA;
                    tx_word = word_for(0);
                end
            end
            default:
            begin
                if (bc < STOP_BITS)
                    r.level = (bc == 0) && (t < hi_short);
                else
                    r.level = (t < hi_short) || ((t < hi_long) && !tx_word[bc - STOP_BITS]);
                if (next_count(t, per_bit) && next_count(bc, WORD_BITS + STOP_BITS))
                begin
                    if (next_count(wc, frame_len))
                    begin
                        // last tick of the frame: back to idle, counters cleared
                        r.done = 1'b1;
                        busy = 1'b0;
                        t = 0;
                        bc = 0;
                        wc = 0;
                        phase = PH_STOP;
                    end
                    else
                        tx_word = word_for(wc);
                end
            end
        endcase
        tick_cnt = t;
        bit_cnt = bc;
        word_cnt = wc;
        return r;
    endfunction

    function automatic line_result_t predict_item(logic [1:0] m, logic [6:0] idx,
                                                  logic [7:0] val, logic [8:0] tot);
        line_result_t r;
        r = '0;
        if (m == MODE_LOAD)
        begin
            if (!busy)
                msg_copy[idx] = val;
        end
        else if (m == MODE_START)
        begin
            if (!busy)
            begin
                busy = 1'b1;
                frame_len = tot;
                tick_cnt = '0;
                bit_cnt = '0;
                word_cnt = '0;
                phase = PH_STOP;
            end
        end
        else if (m == MODE_TICK && busy)
            r = predict_tick();
        r.busy = busy;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic flag_bit(string what, logic exp_bit, logic got_bit);
        if (exp_bit !== got_bit)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch %s: expected %0b, got %0b", what, exp_bit, got_bit);
        end
    endtask

    // Valid stays high across back-to-back requests; drop it only ahead of a gap.
    task automatic send_item(logic [1:0] m, logic [6:0] idx, logic [7:0] val, logic [8:0] tot);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        byte_index <= idx;
        byte_value <= val;
        word_total <= tot;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        level_q.push_back(predict_item(m, idx, val, tot));
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(MODE_TICK, 7'($urandom), 8'($urandom), 9'($urandom));
    endtask

    task automatic run_frame();
        while (busy)
            send_tick();
    endtask

    // Hold off new requests until every pending result is back.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (level_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(logic [7:0] bt, logic [7:0] sh, logic [7:0] lh,
                              logic [7:0] pt, logic [7:0] st);
        cfg_idx_t regs [5];
        logic [7:0] vals [5];
        regs = '{CFG_BIT_TICKS, CFG_SHORT_HIGH, CFG_LONG_HIGH, CFG_PRE_TICKS, CFG_STOP_HIGH};
        vals = '{bt, sh, lh, pt, st};
        settle();
        for (int i = 0; i < 5; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        per_bit = bt;
        hi_short = sh;
        hi_long = lh;
        per_pre = pt;
        hi_stop = st;
        @(posedge clk);
    endtask

    task automatic test_fill_store();
        for (int i = 0; i < MSG_BYTES; i++)
        begin
            if (i == 0)
                send_item(MODE_LOAD, 7'(i), 8'hFF, 9'h1FF);
            else if (i == 1)
                send_item(MODE_LOAD, 7'(i), 8'h00, 9'h000);
            else
                send_item(MODE_LOAD, 7'(i), 8'($urandom), 9'($urandom));
        end
    endtask

    task automatic test_idle_items();
        send_item(MODE_TICK, 7'h7F, 8'hFF, 9'h1FF);
        send_item(MODE_NONE, 7'h00, 8'h00, 9'h000);
        send_item(MODE_LOAD, 7'h7F, 8'h00, 9'h1FF);
        send_item(MODE_NONE, 7'h7F, 8'hFF, 9'h1FF);
    endtask

    task automatic test_default_frame();
        send_item(MODE_START, 7'h00, 8'h00, 9'd2);
        // ignored while a frame runs
        send_item(MODE_LOAD, 7'd2, 8'hA5, 9'h000);
        send_item(MODE_START, 7'h7F, 8'hFF, 9'h1FF);
        send_item(MODE_NONE, 7'h7F, 8'hFF, 9'h1FF);
        run_frame();
    endtask

    task automatic test_short_frames();
        set_config(8'd2, 8'd1, 8'd1, 8'd2, 8'd1);
        send_item(MODE_START, 7'h00, 8'h00, 9'd0);
        run_frame();
        send_item(MODE_START, 7'h00, 8'h00, 9'd1);
        run_frame();
    endtask

    task automatic test_period_edges();
        set_config(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_item(MODE_START, 7'h00, 8'h00, 9'd2);
        run_frame();
        set_config(8'd1, 8'd255, 8'd255, 8'd1, 8'd255);
        send_item(MODE_START, 7'h00, 8'h00, 9'd3);
        run_frame();
        set_config(8'd5, 8'd3, 8'd9, 8'd4, 8'd2);
        send_item(MODE_START, 7'h00, 8'h00, 9'd2);
        run_frame();
    endtask

    // one tick per bit period, so the level shows the complement of each data bit directly
    task automatic test_long_frames();
        set_config(8'd1, 8'd0, 8'd1, 8'd1, 8'd1);
        calm = 1'b1;
        send_item(MODE_START, 7'h00, 8'h00, 9'd16);
        run_frame();
        calm = 1'b0;
    endtask

    task automatic test_slow_frame();
        set_config(8'd9, 8'd4, 8'd7, 8'd6, 8'd5);
        send_item(MODE_START, 7'h00, 8'h00, 9'd0);
        run_frame();
    endtask

    task automatic test_random();
        int goal;
        int budget;
        int r;
        int bt;
        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal)
        begin
            bt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
            set_config(8'(bt), 8'($urandom_range(0, bt + 1)), 8'($urandom_range(0, bt + 2)),
                       8'($urandom_range(0, 5)), 8'($urandom_range(0, bt + 1)));
            calm = ($urandom_range(0, 3) == 0);
            budget = items_sent + $urandom_range(150, 350);
            while (items_sent < budget)
            begin
                r = $urandom_range(0, 99);
                if (busy)
                begin
                    if (r < 90)
                        send_tick();
                    else if (r < 93)
                        send_item(MODE_LOAD, 7'($urandom), 8'($urandom), 9'($urandom));
                    else if (r < 96)
                        send_item(MODE_START, 7'($urandom), 8'($urandom), 9'($urandom));
                    else if (r < 99)
                        send_item(MODE_NONE, 7'($urandom), 8'($urandom), 9'($urandom));
                    else
                        settle();
                end
                else
                begin
                    if (r < 25)
                        send_item(MODE_LOAD, 7'($urandom), 8'($urandom), 9'($urandom));
                    else if (r < 50)
                        send_item(MODE_START, 7'($urandom), 8'($urandom),
                                  ($urandom_range(0, 9) < 8) ? 9'($urandom_range(0, 3))
                                                             : 9'($urandom_range(4, 8)));
                    else if (r < 90)
                        send_tick();
                    else
                        send_item(MODE_NONE, 7'($urandom), 8'($urandom), 9'($urandom));
                end
            end
            run_frame();
        end
        calm = 1'b0;
    endtask

    // check each result, then pick the next ready level
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (level_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: result with nothing pending");
            end
            else
            begin
                want = level_q.pop_front();
                flag_bit("tx_level", want.level, tx_level);
                flag_bit("frame_done", want.done, frame_done);
                flag_bit("busy_res", want.busy, busy_res);
            end
        end
        if (stall_left == 0 && !calm && $urandom_range(0, 99) < 25)
            stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 30);
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_fill_store();
        test_idle_items();
        test_default_frame();
        test_short_frames();
        test_period_edges();
        test_long_frames();
        test_slow_frame();
        test_random();
        settle();
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/pwft_pkg.sv
design/pwft_msg_store.sv
design/pulse_width_frame_transmitter.sv
sim/tb.sv
